// ===== design/sector_health_monitor_defines.svh =====
// Assertion macros for the sector health monitor.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef SECTOR_HEALTH_MONITOR_DEFINES_SVH
`define SECTOR_HEALTH_MONITOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/shm_pkg.sv =====
// Shared types and constants for the sector health monitor.
// No dependencies; used by shm_ctrl, shm_datapath and the top level.
package shm_pkg;

  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 96;
  localparam int unsigned SectorW  = 48;
  localparam int unsigned LatW     = 24;
  localparam int unsigned CrcW     = 32;
  localparam int unsigned GradeW   = 7;
  localparam int unsigned HoursW   = 14;
  localparam int unsigned IntvW    = 26;
  localparam int unsigned QuotW    = 14;  // rate quotient, at most 10000
  localparam int unsigned MulSteps = 5;   // set bits of 10000
  localparam int unsigned CntW     = 4;

  typedef logic [1:0] remap_kind_t;
  localparam remap_kind_t RemapNone = 2'd0;
  localparam remap_kind_t RemapRead = 2'd1;
  localparam remap_kind_t RemapPrev = 2'd2;

  localparam logic [GradeW-1:0] GradeFail = 7'd0;
  localparam logic [GradeW-1:0] GradeSlow = 7'd10;
  localparam logic [GradeW-1:0] GradeLate = 7'd30;
  localparam logic [GradeW-1:0] GradeMarg = 7'd60;
  localparam logic [GradeW-1:0] GradeCap  = 7'd70;
  localparam logic [GradeW-1:0] GradeGood = 7'd100;
  localparam logic [GradeW-1:0] WarnBelow = 7'd50;
  localparam logic [GradeW-1:0] RemapLow  = 7'd20;
  localparam logic [GradeW-1:0] RemapMid  = 7'd40;

  localparam logic [LatW-1:0] LatSlow = 24'd100000;
  localparam logic [LatW-1:0] LatLate = 24'd50000;
  localparam logic [LatW-1:0] LatMarg = 24'd20000;

  localparam logic [CrcW-1:0] CrcZeros = 32'h0000_0000;
  localparam logic [CrcW-1:0] CrcOnes  = 32'hFFFF_FFFF;

  localparam logic [GradeW-1:0] ScoreMax   = 7'd100;
  localparam logic [GradeW-1:0] BaseBad    = 7'd0;
  localparam logic [GradeW-1:0] BasePoor   = 7'd30;
  localparam logic [GradeW-1:0] BaseFair   = 7'd70;
  localparam logic [GradeW-1:0] BaseOk     = 7'd85;
  localparam logic [GradeW-1:0] MinusHigh  = 7'd15;
  localparam logic [GradeW-1:0] MinusMid   = 7'd10;
  localparam logic [GradeW-1:0] MinusLow   = 7'd5;
  localparam logic [QuotW-1:0]  ErrRateHi  = 14'd100;
  localparam logic [QuotW-1:0]  ErrRateMid = 14'd10;
  localparam logic [QuotW-1:0]  ErrRateLo  = 14'd1;
  localparam logic [QuotW-1:0]  WrnRateHi  = 14'd50;
  localparam logic [QuotW-1:0]  WrnRateLo  = 14'd10;

  localparam logic [GradeW-1:0] Band8 = 7'd30;
  localparam logic [GradeW-1:0] Band4 = 7'd50;
  localparam logic [GradeW-1:0] Band2 = 7'd70;
  localparam logic [GradeW-1:0] Band1 = 7'd85;

  localparam logic [HoursW-1:0] HoursMax   = 14'd8760;
  localparam logic [HoursW-1:0] HoursReset = 14'd24;
  localparam logic [IntvW-1:0]  SecPerHour = 26'd3600;

  // 10000 = 2^4 + 2^8 + 2^9 + 2^10 + 2^13
  function automatic logic [3:0] mul_shift(input logic [2:0] idx);
    logic [3:0] s;
    unique case (idx)
      3'd0:    s = 4'd4;
      3'd1:    s = 4'd8;
      3'd2:    s = 4'd9;
      3'd3:    s = 4'd10;
      default: s = 4'd13;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic       take;
    logic       mul_step;
    logic [2:0] mul_idx;
    logic       div_step;
    logic       save_rate;
    logic       pass;       // 0: error rate, 1: warning rate
    logic       score;
    logic       emit;
  } shm_cmd_t;

  typedef struct packed {
    logic out_free;
  } shm_sts_t;

endpackage

// ===== design/shm_ctrl.sv =====
// Sequencer of the sector health monitor: input handshake and the
// multiply/divide schedule of the end-of-pass rescoring. Uses shm_pkg.
module shm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  shm_pkg::shm_sts_t   sts_i,
  output shm_pkg::shm_cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StMul   = 6'b000010,
    StDiv   = 6'b000100,
    StSave  = 6'b001000,
    StScore = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [shm_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     pass_q, pass_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.pass    = pass_q;
    cmd_o.mul_idx = cnt_q[2:0];
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          cnt_d      = '0;
          pass_d     = 1'b0;
          state_d    = in_last_i ? StMul : StEmit;
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == shm_pkg::CntW'(shm_pkg::MulSteps - 1)) begin
          cnt_d   = '0;
          state_d = StDiv;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == shm_pkg::CntW'(shm_pkg::QuotW - 1)) begin
          state_d = StSave;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StSave: begin
        cmd_o.save_rate = 1'b1;
        cnt_d = '0;
        if (pass_q) begin
          state_d = StScore;
        end else begin
          pass_d  = 1'b1;
          state_d = StMul;
        end
      end
      StScore: begin
        cmd_o.score = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
    end
  end

endmodule

// ===== design/shm_datapath.sv =====
// Datapath of the sector health monitor: grading, counters, shift-add
// multiply and restoring divide for rates, score, interval, output register.
// Uses shm_pkg; driven by shm_ctrl.
module shm_datapath #(
  parameter int unsigned CountW = 40
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  shm_pkg::shm_cmd_t                  cmd_i,
  output shm_pkg::shm_sts_t                  sts_o,
  input  logic [shm_pkg::InDataW-1:0]        in_data_i,
  input  logic                               cfg_we_i,
  input  logic [shm_pkg::HoursW-1:0]         cfg_wdata_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [shm_pkg::OutDataW-1:0]       out_data_o,
  output shm_pkg::remap_kind_t               out_kind_o
);

  localparam int unsigned AccW = CountW + shm_pkg::QuotW;
  localparam int unsigned QW   = shm_pkg::QuotW;

  // input word fields
  logic                        in_failed;
  logic [shm_pkg::LatW-1:0]    in_lat;
  logic [shm_pkg::CrcW-1:0]    in_crc;
  logic                        in_coin;
  logic [shm_pkg::SectorW-1:0] in_sector;

  assign in_failed = in_data_i[0];
  assign in_lat    = in_data_i[24:1];
  assign in_crc    = in_data_i[56:25];
  assign in_coin   = in_data_i[57];
  assign in_sector = in_data_i[105:58];

  // per-sector grading
  logic [shm_pkg::GradeW-1:0] grade;
  logic                       warn;
  shm_pkg::remap_kind_t       kind;

  always_comb begin
    warn = 1'b0;
    kind = shm_pkg::RemapNone;
    if (in_failed) begin
      grade = shm_pkg::GradeFail;
      kind  = shm_pkg::RemapRead;
    end else begin
      priority if (in_lat > shm_pkg::LatSlow) grade = shm_pkg::GradeSlow;
      else if (in_lat > shm_pkg::LatLate)     grade = shm_pkg::GradeLate;
      else if (in_lat > shm_pkg::LatMarg)     grade = shm_pkg::GradeMarg;
      else                                    grade = shm_pkg::GradeGood;
      if ((in_crc == shm_pkg::CrcZeros || in_crc == shm_pkg::CrcOnes) &&
          grade > shm_pkg::GradeCap) begin
        grade = shm_pkg::GradeCap;
      end
      if (grade < shm_pkg::WarnBelow) begin
        warn = 1'b1;
        if (grade < shm_pkg::RemapLow || (grade < shm_pkg::RemapMid && in_coin)) begin
          kind = shm_pkg::RemapPrev;
        end
      end
    end
  end

  // item registers
  logic [shm_pkg::GradeW-1:0]  grade_q;
  logic                        fail_q, warn_q;
  shm_pkg::remap_kind_t        kind_q;
  logic [shm_pkg::SectorW-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      grade_q <= grade;
      fail_q  <= in_failed;
      warn_q  <= warn;
      kind_q  <= kind;
      addr_q  <= (kind != shm_pkg::RemapNone) ? in_sector : '0;
    end
  end

  // saturating counters, health score, scan hours
  logic [CountW-1:0]          scan_q, err_q, wrn_q;
  logic [shm_pkg::GradeW-1:0] health_q, health_d;
  logic [shm_pkg::HoursW-1:0] hours_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      err_q    <= '0;
      wrn_q    <= '0;
      health_q <= shm_pkg::ScoreMax;
      hours_q  <= shm_pkg::HoursReset;
    end else begin
      if (cmd_i.take) begin
        if (!(&scan_q)) scan_q <= scan_q + 1'b1;
        if (in_failed && !(&err_q)) err_q <= err_q + 1'b1;
        if (warn && !(&wrn_q)) wrn_q <= wrn_q + 1'b1;
      end
      if (cmd_i.score) health_q <= health_d;
      if (cfg_we_i) hours_q <= cfg_wdata_i;
    end
  end

  // rate = floor(n * 10000 / scanned): shift-add multiply, then 14 divide steps
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CountW-1:0] num;
  logic [CountW:0]   top, diff;
  logic              ge;

  assign num  = cmd_i.pass ? wrn_q : err_q;
  assign top  = acc_q[AccW-1:QW-1];
  assign diff = top - {1'b0, scan_q};
  assign ge   = ~diff[CountW];

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_step) begin
      acc_d = ((cmd_i.mul_idx == 3'd0) ? '0 : acc_q) +
              (AccW'(num) << shm_pkg::mul_shift(cmd_i.mul_idx));
    end else if (cmd_i.div_step) begin
      // remainder in the top bits, quotient shifts in at the bottom
      acc_d = {(ge ? diff[CountW-1:0] : top[CountW-1:0]), acc_q[QW-2:0], ge};
    end
  end

  logic [QW-1:0] err_rate_q, wrn_rate_q;

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.save_rate) begin
      if (cmd_i.pass) wrn_rate_q <= acc_q[QW-1:0];
      else            err_rate_q <= acc_q[QW-1:0];
    end
  end

  // device score
  logic [shm_pkg::GradeW-1:0] base, minus;

  always_comb begin
    base  = shm_pkg::ScoreMax;
    minus = '0;
    if (err_q != '0) begin
      priority if (err_rate_q > shm_pkg::ErrRateHi) base = shm_pkg::BaseBad;
      else if (err_rate_q > shm_pkg::ErrRateMid)    base = shm_pkg::BasePoor;
      else if (err_rate_q > shm_pkg::ErrRateLo)     base = shm_pkg::BaseFair;
      else                                          base = shm_pkg::BaseOk;
    end
    if (wrn_q != '0) begin
      priority if (wrn_rate_q > shm_pkg::WrnRateHi) minus = shm_pkg::MinusHigh;
      else if (wrn_rate_q > shm_pkg::WrnRateLo)     minus = shm_pkg::MinusMid;
      else                                          minus = shm_pkg::MinusLow;
    end
    if (scan_q == '0)        health_d = shm_pkg::ScoreMax;
    else if (base > minus)   health_d = base - minus;
    else                     health_d = '0;
  end

  // next scan interval
  logic [shm_pkg::HoursW-1:0] hours_c;
  logic [shm_pkg::IntvW-1:0]  secs, intv;

  assign hours_c = (hours_q > shm_pkg::HoursMax) ? shm_pkg::HoursMax : hours_q;
  assign secs    = shm_pkg::IntvW'(hours_c) * shm_pkg::SecPerHour;

  always_comb begin
    priority if (health_q < shm_pkg::Band8) intv = secs >> 3;
    else if (health_q < shm_pkg::Band4)     intv = secs >> 2;
    else if (health_q < shm_pkg::Band2)     intv = secs >> 1;
    else if (health_q < shm_pkg::Band1)     intv = secs;
    else                                    intv = secs << 1;
  end

  // output register
  logic                         out_vld_q;
  logic [shm_pkg::OutDataW-1:0] out_data_q;
  shm_pkg::remap_kind_t         out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {6'd0, intv, health_q, addr_q, warn_q, fail_q, grade_q};
      out_kind_q <= kind_q;
    end
  end

  assign sts_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o    = out_vld_q;
  assign out_data_o     = out_data_q;
  assign out_kind_o     = out_kind_q;

endmodule

// ===== design/sector_health_monitor.sv =====
// Channel   Dir  Handshake                 Contents
// s_axis    in   s_axis_tvalid/tready      probed sector word, tlast = end of pass
// m_axis    out  m_axis_tvalid/tready      graded result word, tuser = remap kind
// cfg       in   cfg_we_i                  scan interval in hours
//
// One word at a time. A word without end-of-pass is taken, then emitted into
// the result register. An end-of-pass word first runs two rate computations,
// each a 5-step shift-add multiply by 10000 and a 14-step restoring divide on
// one shared accumulator, then a score step. The result register frees the
// input side; a stalled output holds the next word only at its final step.
// Reset is asynchronous; counters clear, score returns to 100, interval to 24 hours.
// Top level; uses shm_pkg, shm_ctrl, shm_datapath.
`include "sector_health_monitor_defines.svh"

module sector_health_monitor #(
  parameter int unsigned COUNT_WIDTH = 40
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [0] read_failed, [24:1] read_latency, [56:25] page_crc, [57] coin,
  // [105:58] sector_number, [111:106] zero
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [6:0] sector_grade, [7] counted_error, [8] counted_warning,
  // [56:9] remap_address, [63:57] device_score, [89:64] interval_seconds,
  // [95:90] zero
  output logic [95:0]  m_axis_tdata,
  // [1:0] remap_kind
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [13:0]  cfg_wdata_i
);

  shm_pkg::shm_cmd_t cmd;
  shm_pkg::shm_sts_t sts;

  shm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shm_datapath #(
    .CountW (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser)
  );

  // result word fields seen by the checks below
  logic                        in_fire;
  logic                        out_plain;
  logic                        out_failed;
  logic                        out_fail_ok;
  logic [shm_pkg::SectorW-1:0] out_addr;
  logic [shm_pkg::GradeW-1:0]  out_score;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign out_plain   = m_axis_tvalid && (m_axis_tuser == shm_pkg::RemapNone);
  assign out_failed  = m_axis_tvalid && m_axis_tdata[7];
  assign out_fail_ok = (m_axis_tdata[6:0] == shm_pkg::GradeFail) &&
                       (m_axis_tuser == shm_pkg::RemapRead);
  assign out_addr    = m_axis_tdata[56:9];
  assign out_score   = m_axis_tdata[63:57];

  `SHM_ASSERT_NEXT(a_one_word_in_flight, in_fire, !s_axis_tready, "accepted a word while busy")
  `SHM_ASSERT_NOW(a_no_remap_no_addr, out_plain, out_addr == '0, "remap address without remap")
  `SHM_ASSERT_NOW(a_error_grade, out_failed, out_fail_ok, "read error not graded as failure")
  `SHM_ASSERT_NOW(a_score_range, m_axis_tvalid, out_score <= shm_pkg::ScoreMax, "score out of range")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for sector_health_monitor: a typed-in table of sector probes,
// then randomized phases with different scan intervals, checked against a local predictor.
// Depends on shm_pkg and the sector_health_monitor RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned COUNT_W = 40;
  localparam int unsigned NUM_PHASES = 7;

  localparam int unsigned LatW    = shm_pkg::LatW;
  localparam int unsigned CrcW    = shm_pkg::CrcW;
  localparam int unsigned SectorW = shm_pkg::SectorW;
  localparam int unsigned GradeW  = shm_pkg::GradeW;
  localparam int unsigned IntvW   = shm_pkg::IntvW;
  localparam int unsigned HoursW  = shm_pkg::HoursW;

  typedef shm_pkg::remap_kind_t remap_kind_t;
  localparam remap_kind_t RemapNone = shm_pkg::RemapNone;
  localparam remap_kind_t RemapRead = shm_pkg::RemapRead;
  localparam remap_kind_t RemapPrev = shm_pkg::RemapPrev;

  typedef struct {
    logic              failed;
    logic [LatW-1:0]   latency;
    logic [CrcW-1:0]   crc;
    logic              coin;
    logic [SectorW-1:0] sector;
    logic              eop;
  } probe_t;

  typedef struct {
    logic [GradeW-1:0]  grade;
    logic               err;
    logic               warn;
    remap_kind_t        kind;
    logic [SectorW-1:0] addr;
    logic [GradeW-1:0]  score;
    logic [IntvW-1:0]   ivl;
  } verdict_t;

  typedef struct {
    probe_t   probe;
    bit       typed;
    verdict_t want;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [111:0]       s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [95:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               cfg_we_i = 1'b0;
  logic [HoursW-1:0]  cfg_wdata_i = '0;

  // predictor state, starts at the reset values
  logic [COUNT_W-1:0] scanned_cnt = '0;
  logic [COUNT_W-1:0] error_cnt = '0;
  logic [COUNT_W-1:0] warning_cnt = '0;
  logic [GradeW-1:0]  score_now = 7'd100;
  logic [HoursW-1:0]  model_hours = 14'd24;

  verdict_t     pending_verdicts[$];
  plan_row_t    directed_plan[$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  send_run = 0;
  bit           send_quiet = 1'b0;
  int unsigned  recv_run = 0;
  bit           recv_quiet = 1'b0;

  sector_health_monitor #(
    .COUNT_WIDTH(COUNT_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // floor(n * 10000 / scanned) > k, done exactly on products
  function automatic bit rate_exceeds(logic [COUNT_W-1:0] n, int unsigned k);
    return (64'(n) * 64'd10000) >= (64'(scanned_cnt) * 64'(k + 1));
  endfunction

  function automatic logic [GradeW-1:0] pass_score();
    int unsigned base = 100;
    int unsigned minus = 0;
    if (scanned_cnt == '0) return 7'd100;
    if (error_cnt != '0) begin
      if (rate_exceeds(error_cnt, 100)) base = 0;
      else if (rate_exceeds(error_cnt, 10)) base = 30;
      else if (rate_exceeds(error_cnt, 1)) base = 70;
      else base = 85;
    end
    if (warning_cnt != '0) begin
      if (rate_exceeds(warning_cnt, 50)) minus = 15;
      else if (rate_exceeds(warning_cnt, 10)) minus = 10;
      else minus = 5;
    end
    return (base > minus) ? GradeW'(base - minus) : '0;
  endfunction

  function automatic logic [IntvW-1:0] scan_seconds();
    logic [HoursW-1:0] hrs;
    logic [IntvW-1:0]  secs;
    hrs = (model_hours > 14'd8760) ? 14'd8760 : model_hours;
    secs = IntvW'(hrs) * 26'd3600;
    if (score_now < 7'd30) return secs >> 3;
    if (score_now < 7'd50) return secs >> 2;
    if (score_now < 7'd70) return secs >> 1;
    if (score_now < 7'd85) return secs;
    return secs << 1;
  endfunction

  // grades one probe and advances the predictor's counters and score
  function automatic verdict_t grade_sector(probe_t p);
    verdict_t v;
    v.err = p.failed;
    v.warn = 1'b0;
    v.kind = RemapNone;
    if (p.failed) begin
      v.grade = 7'd0;
      v.kind = RemapRead;
    end else begin
      if (p.latency > 24'd100000) v.grade = 7'd10;
      else if (p.latency > 24'd50000) v.grade = 7'd30;
      else if (p.latency > 24'd20000) v.grade = 7'd60;
      else v.grade = 7'd100;
      // stuck-looking page data caps an otherwise good grade
      if ((p.crc == '0 || p.crc == '1) && v.grade > 7'd70) v.grade = 7'd70;
      if (v.grade < 7'd50) begin
        v.warn = 1'b1;
        if (v.grade < 7'd20 || (v.grade < 7'd40 && p.coin)) v.kind = RemapPrev;
      end
    end
    v.addr = (v.kind != RemapNone) ? p.sector : '0;
    scanned_cnt = sat_inc(scanned_cnt);
    if (p.failed) error_cnt = sat_inc(error_cnt);
    if (v.warn) warning_cnt = sat_inc(warning_cnt);
    if (p.eop) score_now = pass_score();
    v.score = score_now;
    v.ivl = scan_seconds();
    return v;
  endfunction

  function automatic void add_row(logic f, logic [LatW-1:0] lat, logic [CrcW-1:0] crc,
                                  logic coin, logic [SectorW-1:0] sec, logic eop, bit typed,
                                  logic [GradeW-1:0] g, logic w, remap_kind_t k,
                                  logic [GradeW-1:0] sc, logic [IntvW-1:0] ivl);
    plan_row_t r;
    r.probe = '{failed: f, latency: lat, crc: crc, coin: coin, sector: sec, eop: eop};
    r.typed = typed;
    r.want = '{grade: g, err: f, warn: w, kind: k,
               addr: (k != RemapNone) ? sec : '0, score: sc, ivl: ivl};
    directed_plan.push_back(r);
  endfunction

  // alternates stretches of random gaps with stretches of back-to-back words
  function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit quiet);
    if (run_left == 0) begin
      quiet = ($urandom_range(0, 2) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic probe_t random_probe(int unsigned err_pm, int unsigned slow_pct);
    probe_t p;
    p.failed = ($urandom_range(0, 999) < err_pm);
    if ($urandom_range(0, 99) < slow_pct) begin
      case ($urandom_range(0, 2))
        0: p.latency = 24'($urandom_range(50001, 100000));
        1: p.latency = 24'($urandom_range(100001, 16777215));
        default: begin
          case ($urandom_range(0, 3))
            0: p.latency = 24'd50001;
            1: p.latency = 24'd100000;
            2: p.latency = 24'd100001;
            default: p.latency = 24'hFFFFFF;
          endcase
        end
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: p.latency = 24'($urandom_range(20001, 50000));
        1: begin
          case ($urandom_range(0, 3))
            0: p.latency = 24'd0;
            1: p.latency = 24'd20000;
            2: p.latency = 24'd20001;
            default: p.latency = 24'd50000;
          endcase
        end
        default: p.latency = 24'($urandom_range(0, 20000));
      endcase
    end
    case ($urandom_range(0, 15))
      0: p.crc = '0;
      1: p.crc = '1;
      default: p.crc = $urandom;
    endcase
    p.coin = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 31))
      0: p.sector = '0;
      1: p.sector = '1;
      default: p.sector = {16'($urandom), 32'($urandom)};
    endcase
    p.eop = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  task automatic offer_probe(probe_t p, bit typed, verdict_t fixed);
    int unsigned gap;
    verdict_t v;
    gap = draw_gap(send_run, send_quiet);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {6'b0, p.sector, p.coin, p.crc, p.latency, p.failed};
    s_axis_tlast  <= p.eop;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    v = grade_sector(p);
    if (typed) pending_verdicts.push_back(fixed);
    else       pending_verdicts.push_back(v);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_hours(logic [HoursW-1:0] h);
    cfg_wdata_i <= h;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_hours = h;
  endtask

  task automatic check_verdict(verdict_t got);
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result word with nothing expected: grade %0d score %0d addr %h",
                 got.grade, got.score, got.addr);
    end else begin
      want = pending_verdicts.pop_front();
      if (got.grade !== want.grade || got.err !== want.err || got.warn !== want.warn ||
          got.kind !== want.kind || got.addr !== want.addr || got.score !== want.score ||
          got.ivl !== want.ivl) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d (expected / actual):", results_seen);
          $display("  grade %0d/%0d err %b/%b warn %b/%b kind %0d/%0d",
                   want.grade, got.grade, want.err, got.err, want.warn, got.warn,
                   want.kind, got.kind);
          $display("  addr %h/%h score %0d/%0d interval %0d/%0d",
                   want.addr, got.addr, want.score, got.score, want.ivl, got.ivl);
        end
      end
    end
  endtask

  // result side
  initial begin
    int unsigned gap;
    verdict_t got;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      // one long hold-off so the block backs up into its input
      gap = (results_seen == 250) ? 400 : draw_gap(recv_run, recv_quiet);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_seen++;
      got.grade = m_axis_tdata[6:0];
      got.err   = m_axis_tdata[7];
      got.warn  = m_axis_tdata[8];
      got.addr  = m_axis_tdata[56:9];
      got.score = m_axis_tdata[63:57];
      got.ivl   = m_axis_tdata[89:64];
      got.kind  = remap_kind_t'(m_axis_tuser);
      check_verdict(got);
    end
  end

  // stimulus
  initial begin
    int unsigned phase_len[NUM_PHASES];
    int unsigned phase_err[NUM_PHASES];   // per mille
    int unsigned phase_slow[NUM_PHASES];  // percent
    logic [HoursW-1:0] phase_hours[NUM_PHASES];
    logic [HoursW-1:0] h;
    verdict_t none;
    phase_len   = '{90, 90, 90, 90, 90, 300, 85};
    phase_err   = '{0, 0, 0, 0, 0, 0, 60};
    phase_slow  = '{8, 15, 5, 20, 10, 2, 30};
    phase_hours = '{14'd1, 14'd8760, 14'h3FFF, 14'd0, 14'd0, 14'd8761, 14'd777};
    none = '{grade: '0, err: 1'b0, warn: 1'b0, kind: RemapNone, addr: '0,
             score: '0, ivl: '0};

    // reset interval is 24 h; score 100 or 85 doubles it, score 0 divides by 8
    add_row(0, 24'd0,      32'h1234_5678, 0, 48'd1,          1, 1, 100, 0, RemapNone, 100,
            172800);
    add_row(0, 24'hFFFFFF, 32'hA5A5_5A5A, 0, 48'd0,          1, 1, 10,  1, RemapPrev, 85,
            172800);
    add_row(1, 24'hFFFFFF, 32'hFFFF_FFFF, 1, 48'hFFFF_FFFF_FFFF, 0, 1, 0, 0, RemapRead, 85,
            172800);
    add_row(0, 24'd100000, 32'h0000_0001, 0, 48'd5,          0, 1, 30,  1, RemapNone, 85,
            172800);
    add_row(0, 24'd100001, 32'h0BAD_F00D, 1, 48'd6,          0, 1, 10,  1, RemapPrev, 85,
            172800);
    add_row(0, 24'd50000,  32'h7FFF_FFFF, 1, 48'd7,          0, 1, 60,  0, RemapNone, 85,
            172800);
    add_row(0, 24'd50001,  32'h8000_0000, 1, 48'h8000_0000_0000, 0, 1, 30, 1, RemapPrev, 85,
            172800);
    add_row(0, 24'd20000,  32'hDEAD_BEEF, 1, 48'd9,          0, 1, 100, 0, RemapNone, 85,
            172800);
    add_row(0, 24'd20001,  32'hC0FF_EE00, 0, 48'd10,         0, 1, 60,  0, RemapNone, 85,
            172800);
    add_row(0, 24'd0,      32'h0000_0000, 0, 48'd11,         0, 1, 70,  0, RemapNone, 85,
            172800);
    add_row(0, 24'd0,      32'hFFFF_FFFF, 1, 48'd12,         0, 1, 70,  0, RemapNone, 85,
            172800);
    add_row(0, 24'd60000,  32'h0000_0000, 0, 48'd13,         0, 1, 30,  1, RemapNone, 85,
            172800);
    add_row(0, 24'd150000, 32'hFFFF_FFFF, 1, 48'd14,         0, 1, 10,  1, RemapPrev, 85,
            172800);
    // one error in 14 sectors drives the base score to zero
    add_row(0, 24'd0,      32'hFFFF_FFFE, 0, 48'hAAAA_AAAA_AAAA, 1, 1, 100, 0, RemapNone, 0,
            10800);
    add_row(0, 24'd30000,  32'h5555_5555, 0, 48'h5555_5555_5555, 1, 0, 0, 0, RemapNone, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i])
      offer_probe(directed_plan[i].probe, directed_plan[i].typed, directed_plan[i].want);

    // error-free phases let the error rate fall through the score bands
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      h = (p == 4) ? 14'($urandom_range(2, 8759)) : phase_hours[p];
      write_hours(h);
      for (int n = 0; n < phase_len[p]; n++)
        offer_probe(random_probe(phase_err[p], phase_slow[p]), 1'b0, none);
    end

    drain_results();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
